@@ src/blm_pkg.sv @@
`timescale 1ns / 1ps
// battery level monitor package: defaults, register indexes, fixed constants
// and the sequencer state type; no dependencies
package blm_pkg;

    localparam int WINDOW_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int RAW_W  = 12;
    localparam int CFG_W  = 16;
    localparam int IDX_CW = 3;
    localparam int TIME_W = 32;
    localparam int LVL_W  = 16;
    localparam int MV_W   = 16;

    localparam logic [IDX_CW-1:0] CFG_RAW_MIN   = 3'd0;
    localparam logic [IDX_CW-1:0] CFG_RAW_MAX   = 3'd1;
    localparam logic [IDX_CW-1:0] CFG_INTERVAL  = 3'd2;
    localparam logic [IDX_CW-1:0] CFG_LOW_THR   = 3'd3;
    localparam logic [IDX_CW-1:0] CFG_EMPTY_MV  = 3'd4;
    localparam logic [IDX_CW-1:0] CFG_FULL_MV   = 3'd5;

    localparam logic [RAW_W-1:0] RAW_MIN_RST  = 12'd0;
    localparam logic [RAW_W-1:0] RAW_MAX_RST  = 12'd4095;
    localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd0;
    localparam logic [CFG_W-1:0] LOW_THR_RST  = 16'd3300;
    localparam logic [CFG_W-1:0] EMPTY_MV_RST = 16'd3000;
    localparam logic [CFG_W-1:0] FULL_MV_RST  = 16'd4200;

    localparam logic [CFG_W-1:0] DEFAULT_INTERVAL_S = 16'd3;
    localparam int               MS_PER_S           = 1000;
    localparam int               LOW_HOLD_MS        = 10000;
    localparam logic [LVL_W-1:0] LEVEL_FULL         = 16'hFFFF;
    localparam logic [3:0]       DIV_LAST           = 4'd15;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_LEVEL,
        S_DIV_LVL,
        S_MUL,
        S_DIV_MV,
        S_FINISH,
        S_OUT
    } state_t;

endpackage

@@ src/battery_level_monitor.sv @@
`timescale 1ns / 1ps
// battery level monitor top level: sample ring, running sum, serial divider
// depends on blm_pkg and blm_ram
//
// One battery check is taken per input transfer and gives exactly one result
// transfer. A failed read (zero sample) goes from idle straight to the output
// state; a check with no report due first updates the ring and the sum. A
// check that reports also runs two 16-step passes through the shared
// bit-serial divider (level scaling, then voltage scaling), skipping the level
// pass when the level needs no divide (saturated or zero). The input is ready
// again once the result sits in the output register, so no new input is taken
// while a check is in progress. The ring lives in a ram; entries not yet
// written read as zero by way of a fill flag, so no clearing pass follows
// reset. A new input is taken while an earlier result still waits in the
// output register. Configuration writes take effect at once.
module battery_level_monitor
    import blm_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   is_charging,
    input  logic [TIME_W-1:0]      now_ms,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   report_valid,
    output logic [LVL_W-1:0]       level_q16,
    output logic [MV_W-1:0]        voltage_mv,
    output logic                   critical,
    output logic                   read_failed,
    input  logic                   cfg_we,
    input  logic [IDX_CW-1:0]      cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int IDX_W = WINDOW > 1 ? $clog2(WINDOW) : 1;
    localparam int WL    = $clog2(WINDOW);
    localparam int SUM_W = SAMPLE_BITS + WL;
    localparam int DEN_W = RAW_W + WL;
    localparam int CW    = SUM_W > DEN_W ? SUM_W : DEN_W;
    localparam int NUM_W = SUM_W + LVL_W;
    localparam int DV_W  = DEN_W > MV_W ? DEN_W : MV_W;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_BITS) - 1));

    state_t state_reg, state_next;

    logic [RAW_W-1:0] raw_min_reg, raw_max_reg;
    logic [CFG_W-1:0] interval_reg, low_thr_reg, empty_mv_reg, full_mv_reg;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              full_reg, full_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [TIME_W-1:0] low_since_reg, low_since_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                   chg_reg, chg_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [LVL_W-1:0]       level_reg, level_next;
    logic                   neg_reg, neg_next;
    logic [DV_W-1:0]        rem_reg, rem_next;
    logic [DV_W-1:0]        dden_reg, dden_next;
    logic [LVL_W-1:0]       numlo_reg, numlo_next;
    logic [LVL_W-1:0]       quo_reg, quo_next;
    logic                   res_rep_reg, res_rep_next;
    logic [LVL_W-1:0]       res_lvl_reg, res_lvl_next;
    logic [MV_W-1:0]        res_mv_reg, res_mv_next;
    logic                   res_crit_reg, res_crit_next;
    logic                   res_fail_reg, res_fail_next;
    logic                   rep_reg, rep_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [MV_W-1:0]        mv_reg, mv_next;
    logic                   crit_reg, crit_next;
    logic                   fail_reg, fail_next;

    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // datapath terms
    logic [SAMPLE_BITS-1:0] old_smp;
    logic [CFG_W-1:0]       ival;
    logic                   due;
    logic [CW-1:0]          lo_ext, sum_ext, den_ext, numhi_ext;
    logic [SUM_W-1:0]       dval;
    logic [NUM_W-1:0]       num;
    logic [DEN_W-1:0]       den;
    logic                   in_range;
    logic [DV_W:0]          trial, dsub;
    logic                   ge;
    logic [DV_W-1:0]        rem_step;
    logic [LVL_W-1:0]       quo_step;
    logic [CFG_W:0]         vdiff;
    logic [CFG_W-1:0]       vmag;
    logic [2*LVL_W-1:0]     prod;
    logic [MV_W-1:0]        mv_calc;
    logic                   low_now;
    logic                   hold_over;

    blm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (smp_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign report_valid = rep_reg;
    assign level_q16    = lvl_reg;
    assign voltage_mv   = mv_reg;
    assign critical     = crit_reg;
    assign read_failed  = fail_reg;
    assign ram_we       = (state_reg == S_SUM);

    assign old_smp  = full_reg ? ram_rdata : '0;
    assign ival     = (interval_reg == '0) ? DEFAULT_INTERVAL_S : interval_reg;
    assign due      = {1'b0, now_reg} >
                      ({1'b0, last_reg} + (33'(ival) * 33'(MS_PER_S)));

    assign lo_ext    = CW'(raw_min_reg) * CW'(WINDOW);
    assign sum_ext   = CW'(sum_reg);
    assign den       = DEN_W'(CW'(raw_max_reg - raw_min_reg) * CW'(WINDOW));
    assign den_ext   = CW'(den);
    assign in_range  = (raw_max_reg > raw_min_reg) && (sum_ext > lo_ext);
    assign dval      = SUM_W'(sum_ext - lo_ext);
    assign num       = {dval, {LVL_W{1'b0}}} - NUM_W'(dval);
    assign numhi_ext = CW'(num[NUM_W-1:LVL_W]);

    assign trial    = {rem_reg, numlo_reg[LVL_W-1]};
    assign dsub     = trial - {1'b0, dden_reg};
    assign ge       = trial >= {1'b0, dden_reg};
    assign rem_step = ge ? dsub[DV_W-1:0] : trial[DV_W-1:0];
    assign quo_step = {quo_reg[LVL_W-2:0], ge};

    assign vdiff   = {1'b0, full_mv_reg} - {1'b0, empty_mv_reg};
    assign vmag    = vdiff[CFG_W] ? CFG_W'(-vdiff) : vdiff[CFG_W-1:0];
    assign prod    = (2*LVL_W)'(level_reg) * (2*LVL_W)'(vmag);
    assign mv_calc = neg_reg ? MV_W'(empty_mv_reg - quo_reg) : MV_W'(empty_mv_reg + quo_reg);
    assign low_now = (mv_calc < low_thr_reg) && !chg_reg;
    assign hold_over = {1'b0, now_reg} > ({1'b0, low_since_reg} + 33'(LOW_HOLD_MS));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        low_since_next = low_since_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        smp_next       = smp_reg;
        chg_next       = chg_reg;
        now_next       = now_reg;
        level_next     = level_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dden_next      = dden_reg;
        numlo_next     = numlo_reg;
        quo_next       = quo_reg;
        res_rep_next   = res_rep_reg;
        res_lvl_next   = res_lvl_reg;
        res_mv_next    = res_mv_reg;
        res_crit_next  = res_crit_reg;
        res_fail_next  = res_fail_reg;
        rep_next       = rep_reg;
        lvl_next       = lvl_reg;
        mv_next        = mv_reg;
        crit_next      = crit_reg;
        fail_next      = fail_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next = sample;
                    chg_next = is_charging;
                    now_next = now_ms;
                    if (sample == '0)
                    begin
                        low_since_next = '0;
                        res_rep_next   = 1'b0;
                        res_lvl_next   = '0;
                        res_mv_next    = '0;
                        res_crit_next  = 1'b0;
                        res_fail_next  = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg - SUM_W'(old_smp) + SUM_W'(smp_reg);
                if (idx_reg == IDX_W'(WINDOW - 1))
                begin
                    idx_next  = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                res_rep_next  = 1'b0;
                res_lvl_next  = '0;
                res_mv_next   = '0;
                res_crit_next = 1'b0;
                res_fail_next = 1'b0;
                if (due)
                begin
                    last_next  = now_reg;
                    state_next = S_LEVEL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_LEVEL:
            begin
                if (!in_range)
                begin
                    level_next = '0;
                    state_next = S_MUL;
                end
                else if (numhi_ext >= den_ext)
                begin
                    level_next = LEVEL_FULL;
                    state_next = S_MUL;
                end
                else
                begin
                    rem_next   = DV_W'(numhi_ext);
                    dden_next  = DV_W'(den);
                    numlo_next = num[LVL_W-1:0];
                    cnt_next   = DIV_LAST;
                    state_next = S_DIV_LVL;
                end
            end
            S_DIV_LVL, S_DIV_MV:
            begin
                rem_next   = rem_step;
                quo_next   = quo_step;
                numlo_next = {numlo_reg[LVL_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (state_reg == S_DIV_LVL)
                    begin
                        level_next = quo_step;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_MUL:
            begin
                neg_next   = vdiff[CFG_W];
                rem_next   = DV_W'(prod[2*LVL_W-1:LVL_W]);
                numlo_next = prod[LVL_W-1:0];
                dden_next  = DV_W'(LEVEL_FULL);
                cnt_next   = DIV_LAST;
                state_next = S_DIV_MV;
            end
            S_FINISH:
            begin
                res_rep_next  = 1'b1;
                res_lvl_next  = level_reg;
                res_mv_next   = mv_calc;
                res_fail_next = 1'b0;
                res_crit_next = 1'b0;
                if (!low_now)
                begin
                    low_since_next = '0;
                end
                else if (low_since_reg == '0)
                begin
                    low_since_next = now_reg;
                end
                else
                begin
                    res_crit_next = hold_over;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    rep_next       = res_rep_reg;
                    lvl_next       = res_lvl_reg;
                    mv_next        = res_mv_reg;
                    crit_next      = res_crit_reg;
                    fail_next      = res_fail_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            last_reg      <= '0;
            low_since_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            full_reg      <= full_next;
            sum_reg       <= sum_next;
            last_reg      <= last_next;
            low_since_reg <= low_since_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_min_reg  <= RAW_MIN_RST;
            raw_max_reg  <= RAW_MAX_RST;
            interval_reg <= INTERVAL_RST;
            low_thr_reg  <= LOW_THR_RST;
            empty_mv_reg <= EMPTY_MV_RST;
            full_mv_reg  <= FULL_MV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RAW_MIN:  raw_min_reg  <= cfg_data[RAW_W-1:0];
                CFG_RAW_MAX:  raw_max_reg  <= cfg_data[RAW_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_LOW_THR:  low_thr_reg  <= cfg_data;
                CFG_EMPTY_MV: empty_mv_reg <= cfg_data;
                CFG_FULL_MV:  full_mv_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        chg_reg      <= chg_next;
        now_reg      <= now_next;
        level_reg    <= level_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        dden_reg     <= dden_next;
        numlo_reg    <= numlo_next;
        quo_reg      <= quo_next;
        res_rep_reg  <= res_rep_next;
        res_lvl_reg  <= res_lvl_next;
        res_mv_reg   <= res_mv_next;
        res_crit_reg <= res_crit_next;
        res_fail_reg <= res_fail_next;
        rep_reg      <= rep_next;
        lvl_reg      <= lvl_next;
        mv_reg       <= mv_next;
        crit_reg     <= crit_next;
        fail_reg     <= fail_next;
    end

    // running sum stays within the window total
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("running sum out of range");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_LVL || state_reg == S_DIV_MV) |-> rem_reg < dden_reg)
        else $error("divider remainder not reduced");

    // failed read never carries a report
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fail_reg) |-> (!rep_reg && !crit_reg && lvl_reg == '0))
        else $error("failed read result carries report data");

    // critical only comes with a report
    a_crit_rep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && crit_reg) |-> rep_reg)
        else $error("critical without report");

    // a good sample goes to the ring update next
    a_good_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sample != '0) |=> state_reg == S_SUM)
        else $error("valid sample skipped ring update");

endmodule

@@ src/blm_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module blm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
